[hw/rtl/dht_pkg.sv]
// shared types and constants for the double hashing table
package dht_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int KEY_BITS  = 14;
  localparam int SLOT_BITS = $clog2(MAX_SLOTS);
  localparam int SIZE_BITS = SLOT_BITS + 1;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // slot state codes
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KEY_BITS-1:0] key;
  } dht_cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [SLOT_BITS-1:0] slot;
  } dht_res_t;

  // write request into the slot store
  typedef struct packed {
    logic                 en;
    logic                 key_en;
    logic [SLOT_BITS-1:0] addr;
    logic [1:0]           state;
    logic [KEY_BITS-1:0]  key;
  } dht_wr_t;

  // registered read data from the slot store
  typedef struct packed {
    logic [1:0]          state;
    logic [KEY_BITS-1:0] key;
  } dht_rd_t;

endpackage

[hw/rtl/dht_divmod.sv]
// iterative remainder unit, one dividend bit per cycle
module dht_divmod import dht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [KEY_BITS-1:0]  dividend,
  input  logic [SIZE_BITS-1:0] divisor,
  output logic                 done,
  output logic [SIZE_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(KEY_BITS);

  logic                 run;
  logic [CNT_W-1:0]     cnt;
  logic [KEY_BITS-1:0]  sh;
  logic [SIZE_BITS-1:0] dv;
  logic [SIZE_BITS:0]   shifted;
  logic [SIZE_BITS:0]   trial;

  // restoring step: shift in next bit, subtract when it fits
  always_comb begin
    shifted = {rem, sh[KEY_BITS-1]};
    if (shifted >= {1'b0, dv}) begin
      trial = shifted - {1'b0, dv};
    end else begin
      trial = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        sh  <= dividend;
        dv  <= divisor;
        rem <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= trial[SIZE_BITS-1:0];
        sh  <= sh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(KEY_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/dht_store.sv]
// slot state and key memories with per-slot valid bits
module dht_store import dht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SLOT_BITS-1:0] rd_addr,
  input  dht_wr_t              wr,
  output dht_rd_t              rd
);

  logic [1:0]          state_mem [MAX_SLOTS];
  logic [KEY_BITS-1:0] key_mem   [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid;
  logic [1:0]          state_q;
  logic                valid_q;
  logic [KEY_BITS-1:0] key_q;

  // valid bits: a slot never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      state_mem[wr.addr] <= wr.state;
    end
    if (wr.en && wr.key_en) begin
      key_mem[wr.addr] <= wr.key;
    end
    state_q <= state_mem[rd_addr];
    valid_q <= valid[rd_addr];
    key_q   <= key_mem[rd_addr];
  end

  assign rd = '{state: (valid_q ? state_q : ST_EMPTY), key: key_q};

endmodule

[hw/rtl/double_hash_table.sv]
// top level: sequencer driving the remainder unit and the probe loop
//
//   channel  signals                        transfer
//   cmd      start, busy, cmd               start high while busy low
//   result   done, result                   done high, one cycle, no stall
//   config   cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// an item holds busy for its two remainders (14 steps each in the shared
// remainder unit), then for each probe through S_RD and S_CHK, as set by
// the registered read of the slot store; the result strobe comes in the same
// cycle busy drops, so a new command is taken only once the last one is through.
// reset empties every slot at once through valid bits and sets table_size 64.
// results cannot be stalled; busy stays high until the result strobe.
module double_hash_table import dht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  dht_cmd_t             cmd,
  output logic                 done,
  output dht_res_t             result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIZE_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_STRIDE,
    S_RD,
    S_CHK
  } seq_t;

  seq_t                 state;
  logic [SIZE_BITS-1:0] table_size;
  logic [SIZE_BITS-1:0] m_eff;
  logic [SIZE_BITS-1:0] m;
  logic [1:0]           op;
  logic [KEY_BITS-1:0]  key;
  logic [SLOT_BITS-1:0] pos;
  logic [SLOT_BITS-1:0] stride;
  logic [SLOT_BITS-1:0] idx;
  logic [SIZE_BITS-1:0] pos_sum;
  logic [SLOT_BITS-1:0] pos_next;

  logic                 div_go;
  logic [KEY_BITS-1:0]  div_dividend;
  logic [SIZE_BITS-1:0] div_divisor;
  logic                 div_done;
  logic [SIZE_BITS-1:0] div_rem;

  dht_wr_t              wr;
  dht_rd_t              rd;
  logic                 last_probe;
  logic                 key_hit;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  // clamp the configured size into the legal range
  always_comb begin
    if (table_size < SIZE_BITS'(2)) begin
      m_eff = SIZE_BITS'(2);
    end else if (table_size > SIZE_BITS'(MAX_SLOTS)) begin
      m_eff = SIZE_BITS'(MAX_SLOTS);
    end else begin
      m_eff = table_size;
    end
  end

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_BITS'(MAX_SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  // remainder unit: first k mod m, then k mod (m-1)
  assign div_go       = (state == S_IDLE && start) || (state == S_BASE && div_done);
  assign div_dividend = (state == S_IDLE) ? cmd.key : key;
  assign div_divisor  = (state == S_IDLE) ? m_eff : m - 1'b1;

  dht_divmod u_divmod (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // next probe position, one compare and subtract
  always_comb begin
    pos_sum = {1'b0, pos} + {1'b0, stride};
    if (pos_sum >= m) begin
      pos_next = SLOT_BITS'(pos_sum - m);
    end else begin
      pos_next = pos_sum[SLOT_BITS-1:0];
    end
  end

  assign last_probe = ({1'b0, idx} == m - 1'b1);
  assign key_hit    = (rd.state == ST_OCCUPIED) && (rd.key == key);

  // store write request for the checked slot
  always_comb begin
    wr.en     = 1'b0;
    wr.key_en = 1'b0;
    wr.addr   = pos;
    wr.state  = ST_OCCUPIED;
    wr.key    = key;
    if (state == S_CHK) begin
      case (op)
        OP_INSERT: begin
          if (rd.state != ST_OCCUPIED) begin
            wr.en     = 1'b1;
            wr.key_en = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (key_hit) begin
            wr.en    = 1'b1;
            wr.state = ST_REMOVED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  dht_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (pos),
    .wr      (wr),
    .rd      (rd)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op    <= cmd.opcode;
            key   <= cmd.key;
            m     <= m_eff;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          if (div_done) begin
            pos   <= div_rem[SLOT_BITS-1:0];
            state <= S_STRIDE;
          end
        end
        S_STRIDE: begin
          if (div_done) begin
            stride <= SLOT_BITS'(div_rem + 1'b1);
            idx    <= '0;
            if (op inside {OP_INSERT, OP_SEARCH, OP_REMOVE}) begin
              state <= S_RD;
            end else begin
              result <= '0;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op == OP_INSERT && rd.state != ST_OCCUPIED) begin
            result.ok   <= 1'b1;
            result.slot <= pos;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else if (op != OP_INSERT && key_hit) begin
            result.ok   <= 1'b1;
            result.slot <= (op == OP_REMOVE) ? '0 : pos;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else if ((op != OP_INSERT && rd.state == ST_EMPTY) || last_probe) begin
            result <= '0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            pos   <= pos_next;
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result always leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // failed operations report slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.slot == '0))
    else $error("failed result with nonzero slot");

  // a remove never reports a slot
  a_remove_slot: assert property (@(posedge clk) disable iff (rst)
    (done && op == OP_REMOVE) |-> (result.slot == '0))
    else $error("remove reported a slot");

  // probe position stays inside the table
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> ({1'b0, pos} < m))
    else $error("probe outside table");

endmodule

[verif/tb_double_hash_table.sv]
// self-checking testbench for the double hashing table: directed rows, then random phases
module tb_double_hash_table import dht_pkg::*; ();

  // opcode with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 125;
  localparam int POOL_KEYS = 12;
  localparam int SIZE_RESET = 64;

  // one directed row: a size write or a command, optionally with a typed-in result
  typedef struct packed {
    logic                 is_cfg;
    logic [SIZE_BITS-1:0] size;
    dht_cmd_t             cmd;
    logic                 typed;
    dht_res_t             res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd5},     1'b1, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd0},     1'b1, '{1'b1, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd16383}, 1'b1, '{1'b1, 6'd63}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd16383}, 1'b1, '{1'b1, 6'd63}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd0},     1'b1, '{1'b1, 6'd0}},
    '{1'b0, 7'd0,   '{OP_REMOVE, 14'd16383}, 1'b1, '{1'b1, 6'd0}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd16383}, 1'b1, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd16383}, 1'b1, '{1'b1, 6'd63}},
    '{1'b0, 7'd0,   '{OP_UNUSED, 14'd16383}, 1'b1, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_REMOVE, 14'd12345}, 1'b1, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_REMOVE, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b1, 7'd0,   '{OP_INSERT, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd7},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd9},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd7},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_REMOVE, 14'd16383}, 1'b0, '{1'b0, 6'd0}},
    '{1'b1, 7'd1,   '{OP_INSERT, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd2},     1'b0, '{1'b0, 6'd0}},
    '{1'b1, 7'd127, '{OP_INSERT, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd7},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_INSERT, 14'd8191},  1'b0, '{1'b0, 6'd0}},
    '{1'b1, 7'd64,  '{OP_INSERT, 14'd0},     1'b0, '{1'b0, 6'd0}},
    '{1'b0, 7'd0,   '{OP_SEARCH, 14'd8191},  1'b0, '{1'b0, 6'd0}}
  };

  // table size per random phase, extremes and out-of-range values among them
  localparam logic [SIZE_BITS-1:0] PHASE_SIZES [PHASES] = '{
    7'd2, 7'd64, 7'd5, 7'd127, 7'd3, 7'd17, 7'd0,
    7'd64, 7'd1, 7'd9, 7'd63, 7'd65, 7'd32, 7'd64
  };

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  dht_cmd_t             cmd;
  logic                 done;
  dht_res_t             result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SIZE_BITS-1:0] cfg_data;

  // shadow copy of the table contents and size
  logic [1:0]          shadow_state [MAX_SLOTS];
  logic [KEY_BITS-1:0] shadow_key [MAX_SLOTS];
  logic [SIZE_BITS-1:0] shadow_size;

  dht_res_t expected_results [$];
  logic [KEY_BITS-1:0] key_pool [POOL_KEYS];

  int fail_cnt;
  int n_items;
  int n_hits;
  int n_misses;
  int n_size_writes;
  int idle_cycles;

  double_hash_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // slot visited by probe number i for key k in a table of m slots
  function automatic int probe_slot(int k, int i, int m);
    int base;
    int stride;
    base = k % m;
    stride = 1 + (k % (m - 1));
    return (base + ((i * stride) % m)) % m;
  endfunction

  // apply one command to the shadow table and return the result it yields
  function automatic dht_res_t table_step(dht_cmd_t c);
    dht_res_t r;
    int m;
    int k;
    int s;
    bit stop;
    r = '0;
    m = int'(shadow_size);
    if (m < 2) m = 2;
    if (m > MAX_SLOTS) m = MAX_SLOTS;
    k = int'(c.key);
    stop = 1'b0;
    for (int i = 0; i < m && !stop; i++) begin
      s = probe_slot(k, i, m);
      case (c.opcode)
        OP_INSERT: begin
          if (shadow_state[s] != ST_OCCUPIED) begin
            shadow_state[s] = ST_OCCUPIED;
            shadow_key[s] = c.key;
            r.ok = 1'b1;
            r.slot = s[SLOT_BITS-1:0];
            stop = 1'b1;
          end
        end
        OP_SEARCH, OP_REMOVE: begin
          if (shadow_state[s] == ST_EMPTY) begin
            stop = 1'b1;
          end else if (shadow_state[s] == ST_OCCUPIED && shadow_key[s] == c.key) begin
            r.ok = 1'b1;
            if (c.opcode == OP_SEARCH) begin
              r.slot = s[SLOT_BITS-1:0];
            end else begin
              shadow_state[s] = ST_REMOVED;
            end
            stop = 1'b1;
          end
        end
        default: stop = 1'b1;
      endcase
    end
    return r;
  endfunction

  // wait until every outstanding result has come back
  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // command transfer; the predicted or typed-in result is queued on acceptance
  task automatic send_cmd(input dht_cmd_t c, input logic typed, input dht_res_t typed_res);
    dht_res_t r;
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = table_step(c);
    expected_results.push_back(typed ? typed_res : r);
    n_items++;
    @(negedge clk);
    start = 1'b0;
    cmd = dht_cmd_t'($urandom);
  endtask

  // size register write, only with the table idle
  task automatic write_size(input logic [SIZE_BITS-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_size = v;
    n_size_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = SIZE_BITS'($urandom);
  endtask

  // result checker
  always @(posedge clk) begin
    dht_res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: ok %0d slot %0d", result.ok, result.slot);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (result.ok !== want.ok) begin
          $error("ok mismatch: expected %0d actual %0d", want.ok, result.ok);
          fail_cnt++;
        end
        if (result.slot !== want.slot) begin
          $error("slot mismatch: expected %0d actual %0d", want.slot, result.slot);
          fail_cnt++;
        end
        if (want.ok) n_hits++;
        else n_misses++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    dht_cmd_t c;
    int roll;
    int idle_pct;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_data = SIZE_BITS'(SIZE_RESET);
    fail_cnt = 0;
    n_items = 0;
    n_hits = 0;
    n_misses = 0;
    n_size_writes = 0;
    shadow_size = SIZE_BITS'(SIZE_RESET);
    for (int s = 0; s < MAX_SLOTS; s++) begin
      shadow_state[s] = ST_EMPTY;
      shadow_key[s] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].is_cfg) write_size(DIR_TABLE[r].size);
      else send_cmd(DIR_TABLE[r].cmd, DIR_TABLE[r].typed, DIR_TABLE[r].res);
    end

    // random phases: mostly keys from a small pool so searches and removes hit
    for (int ph = 0; ph < PHASES; ph++) begin
      write_size(PHASE_SIZES[ph]);
      for (int p = 0; p < POOL_KEYS; p++) begin
        key_pool[p] = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
      end
      // no idling in the last phases, none in some others either
      idle_pct = (ph >= PHASES - 2 || ph % 5 == 3) ? 0 : $urandom_range(5, 50);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) wait_drained();
        // idle burst once the table is free again
        if ($urandom_range(1, 100) <= idle_pct) begin
          while (busy) @(negedge clk);
          repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        roll = $urandom_range(0, 99);
        if (roll < 40) c.opcode = OP_INSERT;
        else if (roll < 70) c.opcode = OP_SEARCH;
        else if (roll < 95) c.opcode = OP_REMOVE;
        else c.opcode = OP_UNUSED;
        if ($urandom_range(0, 3) != 0) c.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        else c.key = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
        send_cmd(c, 1'b0, '0);
      end
    end

    // drain and let the block settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_cnt++;
    end

    $display("covered %0d commands over %0d size settings, table sizes 0 to 127",
             n_items, n_size_writes);
    $display("results: %0d successful, %0d not found, full or unused", n_hits, n_misses);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[double_hash_table.f]
hw/rtl/dht_pkg.sv
hw/rtl/dht_divmod.sv
hw/rtl/dht_store.sv
hw/rtl/double_hash_table.sv
verif/tb_double_hash_table.sv
